[rtl/i2c6_pkg.sv]
// Shared types, bus phase codes, status codes and stream packing for the
// six-byte I2C master. No dependencies; every other file in rtl/ uses it.
`timescale 1ns / 1ps

package i2c6_pkg;

  // Number of data bytes moved per transfer (1 to 8).
  localparam int BYTE_COUNT = 6;

  // Field widths.
  localparam int PAYLOAD_W = 48;
  localparam int IN_W      = 56;
  localparam int OUT_W     = 64;

  // Fixed upper address bits of the target device.
  localparam logic [7:0] ADDR_BASE = 8'h40;

  // Status codes reported with every result.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ADDR_NACK   = 3'd1;
  localparam logic [2:0] ST_DATA_NACK   = 3'd2;
  localparam logic [2:0] ST_STUCK_BEGIN = 3'd3;
  localparam logic [2:0] ST_STUCK_END   = 3'd4;

  // Half-bit bus phases, one-hot.
  typedef enum logic [13:0] {
    PH_IDLE    = 14'b00000000000001,
    PH_START   = 14'b00000000000010,
    PH_ADDR_LO = 14'b00000000000100,
    PH_ADDR_HI = 14'b00000000001000,
    PH_AACK_LO = 14'b00000000010000,
    PH_AACK_HI = 14'b00000000100000,
    PH_DATA_LO = 14'b00000001000000,
    PH_DATA_HI = 14'b00000010000000,
    PH_DACK_LO = 14'b00000100000000,
    PH_DACK_HI = 14'b00001000000000,
    PH_CHECK   = 14'b00010000000000,
    PH_STOP_LO = 14'b00100000000000,
    PH_STOP_HI = 14'b01000000000000,
    PH_DONE    = 14'b10000000000000
  } phase_t;

  // One tick request.
  typedef struct packed {
    logic                 start_request;
    logic                 read_not_write;
    logic [1:0]           device_index;
    logic [PAYLOAD_W-1:0] write_payload;
    logic                 sda_sample;
  } item_t;

  // One tick result.
  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 busy_res;
    logic                 done_res;
    logic [2:0]           status;
    logic [2:0]           failed_byte;
    logic [PAYLOAD_W-1:0] read_payload;
  } result_t;

  // Unpack a request word: fields from the lowest bit up.
  function automatic item_t unpack_item(input logic [IN_W-1:0] d);
    item_t it;
    it.start_request  = d[0];
    it.read_not_write = d[1];
    it.device_index   = d[3:2];
    it.write_payload  = d[51:4];
    it.sda_sample     = d[52];
    return it;
  endfunction

  // Pack a result word: fields from the lowest bit up, zero filled.
  function automatic logic [OUT_W-1:0] pack_result(input result_t r);
    return {6'b0, r.read_payload, r.failed_byte, r.status,
            r.done_res, r.busy_res, r.sda_level, r.scl_level};
  endfunction

  // Write byte k of the payload; byte 0 sits highest. Bytes that fall
  // outside the 48-bit payload read as zero.
  function automatic logic [7:0] payload_byte(input logic [PAYLOAD_W-1:0] pl,
                                              input logic [2:0] k);
    logic [7:0] b;
    logic [3:0] pos;
    b   = 8'h00;
    pos = 4'(BYTE_COUNT - 1) - {1'b0, k};
    if ({1'b0, k} < 4'(BYTE_COUNT)) begin
      for (int j = 0; j < PAYLOAD_W / 8; j++) begin
        if (pos == 4'(j)) begin
          b = pl[8*j +: 8];
        end
      end
    end
    return b;
  endfunction

endpackage

[rtl/i2c6_seq.sv]
// Bus phase sequencer of the six-byte I2C master: transfer state and the
// per-tick drive and status logic. Depends on i2c6_pkg.
`timescale 1ns / 1ps

module i2c6_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  i2c6_pkg::item_t  item,
  output i2c6_pkg::result_t result
);

  i2c6_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [2:0]  byte_cnt_r, byte_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        dir_r, dir_nxt;
  logic [i2c6_pkg::PAYLOAD_W-1:0] buf_r, buf_nxt;
  logic [2:0]  code_r, code_nxt;
  logic [2:0]  nack_r, nack_nxt;

  logic        scl, sda, busy, done;
  logic [3:0]  bit_inc;
  logic [2:0]  byte_inc;

  assign bit_inc  = bit_cnt_r + 4'd1;
  assign byte_inc = byte_cnt_r + 3'd1;

  // Phase decode: drive levels for this tick and the state after it.
  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    shift_nxt    = shift_r;
    dir_nxt      = dir_r;
    buf_nxt      = buf_r;
    code_nxt     = code_r;
    nack_nxt     = nack_r;
    scl          = 1'b1;
    sda          = 1'b1;
    busy         = 1'b1;
    done         = 1'b0;
    case (phase_r)
      i2c6_pkg::PH_START: begin
        sda       = 1'b0;
        phase_nxt = i2c6_pkg::PH_ADDR_LO;
      end
      i2c6_pkg::PH_ADDR_LO: begin
        scl       = 1'b0;
        sda       = shift_r[7];
        phase_nxt = i2c6_pkg::PH_ADDR_HI;
      end
      i2c6_pkg::PH_ADDR_HI: begin
        sda         = shift_r[7];
        shift_nxt   = {shift_r[6:0], 1'b0};
        bit_cnt_nxt = bit_inc;
        phase_nxt   = (bit_inc >= 4'd8) ? i2c6_pkg::PH_AACK_LO : i2c6_pkg::PH_ADDR_LO;
      end
      i2c6_pkg::PH_AACK_LO: begin
        scl       = 1'b0;
        phase_nxt = i2c6_pkg::PH_AACK_HI;
      end
      i2c6_pkg::PH_AACK_HI: begin
        if (item.sda_sample) begin
          code_nxt  = i2c6_pkg::ST_ADDR_NACK;
          phase_nxt = i2c6_pkg::PH_CHECK;
        end else begin
          byte_cnt_nxt = 3'd0;
          bit_cnt_nxt  = 4'd0;
          shift_nxt    = dir_r ? 8'h00 : i2c6_pkg::payload_byte(buf_r, 3'd0);
          phase_nxt    = i2c6_pkg::PH_DATA_LO;
        end
      end
      i2c6_pkg::PH_DATA_LO: begin
        scl       = 1'b0;
        sda       = dir_r | shift_r[7];
        phase_nxt = i2c6_pkg::PH_DATA_HI;
      end
      i2c6_pkg::PH_DATA_HI: begin
        sda         = dir_r | shift_r[7];
        shift_nxt   = {shift_r[6:0], dir_r & item.sda_sample};
        bit_cnt_nxt = bit_inc;
        phase_nxt   = (bit_inc >= 4'd8) ? i2c6_pkg::PH_DACK_LO : i2c6_pkg::PH_DATA_LO;
      end
      i2c6_pkg::PH_DACK_LO: begin
        scl       = 1'b0;
        sda       = ~dir_r;
        phase_nxt = i2c6_pkg::PH_DACK_HI;
      end
      i2c6_pkg::PH_DACK_HI: begin
        sda = ~dir_r;
        if (!dir_r && item.sda_sample) begin
          // Slave refused a write byte: record which one and wind down.
          code_nxt  = i2c6_pkg::ST_DATA_NACK;
          nack_nxt  = byte_cnt_r;
          phase_nxt = i2c6_pkg::PH_CHECK;
        end else begin
          if (dir_r) begin
            buf_nxt = {buf_r[i2c6_pkg::PAYLOAD_W-9:0], shift_r};
          end
          byte_cnt_nxt = byte_inc;
          if (byte_inc == 3'd0 || {1'b0, byte_inc} >= 4'(i2c6_pkg::BYTE_COUNT)) begin
            code_nxt  = i2c6_pkg::ST_OK;
            phase_nxt = i2c6_pkg::PH_CHECK;
          end else begin
            bit_cnt_nxt = 4'd0;
            shift_nxt   = dir_r ? 8'h00 : i2c6_pkg::payload_byte(buf_r, byte_inc);
            phase_nxt   = i2c6_pkg::PH_DATA_LO;
          end
        end
      end
      i2c6_pkg::PH_CHECK: begin
        scl = 1'b0;
        if (!item.sda_sample) begin
          code_nxt  = i2c6_pkg::ST_STUCK_END;
          phase_nxt = i2c6_pkg::PH_DONE;
        end else begin
          phase_nxt = i2c6_pkg::PH_STOP_LO;
        end
      end
      i2c6_pkg::PH_STOP_LO: begin
        scl       = 1'b0;
        sda       = 1'b0;
        phase_nxt = i2c6_pkg::PH_STOP_HI;
      end
      i2c6_pkg::PH_STOP_HI: begin
        sda       = 1'b0;
        phase_nxt = i2c6_pkg::PH_DONE;
      end
      i2c6_pkg::PH_DONE: begin
        busy      = 1'b0;
        done      = 1'b1;
        phase_nxt = i2c6_pkg::PH_IDLE;
      end
      default: begin
        // Idle: latch a new request and check that the bus is free.
        busy      = 1'b0;
        phase_nxt = i2c6_pkg::PH_IDLE;
        if (item.start_request) begin
          dir_nxt      = item.read_not_write;
          nack_nxt     = 3'd0;
          bit_cnt_nxt  = 4'd0;
          byte_cnt_nxt = 3'd0;
          buf_nxt      = item.read_not_write ? '0 : item.write_payload;
          shift_nxt    = i2c6_pkg::ADDR_BASE | {5'b0, item.device_index, item.read_not_write};
          if (!item.sda_sample) begin
            code_nxt  = i2c6_pkg::ST_STUCK_BEGIN;
            phase_nxt = i2c6_pkg::PH_DONE;
          end else begin
            code_nxt  = i2c6_pkg::ST_OK;
            phase_nxt = i2c6_pkg::PH_START;
          end
        end
      end
    endcase
  end

  // Result of this tick, taken from the updated status.
  always_comb begin
    result.scl_level    = scl;
    result.sda_level    = sda;
    result.busy_res     = busy;
    result.done_res     = done;
    result.status       = code_nxt;
    result.failed_byte  = nack_nxt;
    result.read_payload = (!busy && dir_nxt) ? buf_nxt : '0;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= i2c6_pkg::PH_IDLE;
      bit_cnt_r  <= 4'd0;
      byte_cnt_r <= 3'd0;
      dir_r      <= 1'b0;
      code_r     <= i2c6_pkg::ST_OK;
      nack_r     <= 3'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      dir_r      <= dir_nxt;
      code_r     <= code_nxt;
      nack_r     <= nack_nxt;
    end
  end

  // Data shift registers.
  always_ff @(posedge clk) begin
    if (step) begin
      shift_r <= shift_nxt;
      buf_r   <= buf_nxt;
    end
  end

  // The phase register always holds exactly one phase.
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("phase register lost its one-hot code");

  // A finished transfer always returns to idle on the next tick.
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == i2c6_pkg::PH_DONE) |=> (phase_r == i2c6_pkg::PH_IDLE))
    else $error("done tick not followed by idle");

  // Bit counter never runs past one byte.
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= 4'd8)
    else $error("bit counter beyond eight");

endmodule

[rtl/i2c_master_six_byte_transfer.sv]
// Top level of the six-byte I2C master: request and result registers around
// the bus phase sequencer. Depends on i2c6_pkg and i2c6_seq.
`timescale 1ns / 1ps

// Each request is one half-bit bus tick: it carries the sampled SDA level and,
// in the idle tick, the start request with direction, device index and write
// data. Each request yields exactly one result with the SCL/SDA drive for that
// tick, busy/done flags and the status. The block sustains one request per
// clock unless out_tready holds the result register. A request waits in the
// request register while the sequencer works on it; its result is then
// registered in the result register, from which it is offered. The sequencer
// state advances once per request, so throughput is set by the phase update
// between those two registers.
module i2c_master_six_byte_transfer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // start_request[0], read_not_write[1], device_index[3:2],
  // write_payload[51:4], sda_sample[52], zero[55:53]
  input  logic [i2c6_pkg::IN_W-1:0] in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // scl_level[0], sda_level[1], busy_res[2], done_res[3], status[6:4],
  // failed_byte[9:7], read_payload[57:10], zero[63:58]
  output logic [i2c6_pkg::OUT_W-1:0] out_tdata
);

  i2c6_pkg::item_t   item_r;
  logic              in_valid_r;
  logic              out_valid_r;
  logic [i2c6_pkg::OUT_W-1:0] out_data_r;
  i2c6_pkg::result_t result;
  logic              advance;
  logic              in_take;

  // A request moves to the result register when that register is free.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  // Request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= i2c6_pkg::unpack_item(in_tdata);
    end
  end

  i2c6_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item_r),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= i2c6_pkg::pack_result(result);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
